// ----- design/itaf_pkg.sv -----
// Shared constants for the integer to ASCII formatter.
`default_nettype none
package itaf_pkg;

    localparam int VALUE_W    = 32;              // numeric value width
    localparam int OPCODE_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int DEC_DIGITS = 10;              // enough for 2**32 - 1
    localparam int HEX_DIGITS = VALUE_W / NIB_W;
    localparam int BUF_W      = DEC_DIGITS * NIB_W;
    localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
    localparam int STEP_W     = $clog2(VALUE_W);
    localparam int IN_TDATA_W = ((OPCODE_W + VALUE_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_CHAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DEC  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_HEX  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_A_LOW = 8'h61;
    localparam logic [BYTE_W-1:0] ASCII_MINUS = 8'h2d;
    localparam logic [BYTE_W-1:0] ASCII_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] ASCII_CR    = 8'h0d;

    // Nibble to ASCII digit, lowercase for 10..15.
    function automatic logic [BYTE_W-1:0] digit_char(input logic [NIB_W-1:0] d);
        logic [BYTE_W-1:0] r;
        if (d < NIB_W'(10)) begin
            r = ASCII_ZERO + BYTE_W'(d);
        end else begin
            r = ASCII_A_LOW + BYTE_W'(d) - BYTE_W'(10);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/int_to_ascii_formatter.sv -----
// Top level: integer to ASCII text formatter with stream input and output.
//
// Input channel (i_s_*): one item per conversion, tdata = {value, opcode}.
//   opcode 0 prints the low byte of value as a character (a newline is
//   followed by a carriage return), 1 prints value as signed decimal,
//   2 prints value as unsigned lowercase hex; 3 is taken and dropped.
// Output channel (o_m_*): one ASCII byte per item, tlast on the final byte
//   of each input item's text.
// Timing: one input item at a time; o_s_tready is high only when idle.
//   Before the first byte is loaded, a character goes straight to output;
//   hex runs the leading-zero trim; decimal runs the bit-serial BCD
//   converter and then the leading-zero trim. Later bytes follow one per
//   cycle while i_m_tready stays high, and an item holds the input until
//   its last byte is loaded into the output register.
// Stall: a held byte stays on o_m_tdata with o_m_tvalid high; the
//   formatter waits and loses nothing. A new item is accepted while the
//   last byte of the previous one still waits in the output register.
// Reset (i_rst_n low, synchronous): back to idle, output empty.
`default_nettype none
module int_to_ascii_formatter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // tdata: [1:0] opcode, [33:2] value, [39:34] zero
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [itaf_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // tdata: [7:0] out_byte
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [itaf_pkg::BYTE_W-1:0]            o_m_tdata,
    output logic                                   o_m_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_TRIM,
        S_EMIT
    } t_state;

    t_state                               r_state;
    logic                                 r_pre;      // prefix byte pending
    logic [itaf_pkg::BYTE_W-1:0]          r_pre_byte; // '-' or the character
    logic                                 r_cr;       // trailing CR pending
    logic [itaf_pkg::CNT_W-1:0]           r_nd;       // digits left in buffer
    logic [itaf_pkg::BUF_W-1:0]           r_buf;      // next digit in top nibble
    logic                                 r_out_valid;
    logic [itaf_pkg::BYTE_W-1:0]          r_out_byte;
    logic                                 r_out_last;

    logic                                 n_accept;
    logic [itaf_pkg::OPCODE_W-1:0]        n_op;
    logic [itaf_pkg::VALUE_W-1:0]         n_val;
    logic                                 n_neg;
    logic [itaf_pkg::VALUE_W-1:0]         n_mag;
    logic                                 n_slot;
    logic                                 n_load;     // output register loads a byte
    logic [itaf_pkg::NIB_W-1:0]           n_top;
    logic                                 n_conv_done;
    logic [itaf_pkg::BUF_W-1:0]           n_bcd;

    assign n_op     = i_s_tdata[itaf_pkg::OPCODE_W-1:0];
    assign n_val    = i_s_tdata[itaf_pkg::OPCODE_W +: itaf_pkg::VALUE_W];
    assign n_neg    = n_val[itaf_pkg::VALUE_W-1];
    assign n_mag    = n_neg ? (itaf_pkg::VALUE_W'(0) - n_val) : n_val;
    assign n_accept = i_s_tvalid && o_s_tready;
    assign n_slot   = !r_out_valid || i_m_tready;
    assign n_load   = (r_state == S_EMIT) && n_slot;
    assign n_top    = r_buf[itaf_pkg::BUF_W-1 -: itaf_pkg::NIB_W];

    itaf_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_accept && (n_op == itaf_pkg::OP_DEC)),
        .i_bin   (n_mag),
        .o_done  (n_conv_done),
        .o_bcd   (n_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pre       <= 1'b0;
            r_cr        <= 1'b0;
            r_nd        <= '0;
        end else begin
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        unique case (n_op)
                            itaf_pkg::OP_CHAR: begin
                                r_pre      <= 1'b1;
                                r_pre_byte <= n_val[itaf_pkg::BYTE_W-1:0];
                                r_cr       <= (n_val[itaf_pkg::BYTE_W-1:0] ==
                                               itaf_pkg::ASCII_LF);
                                r_nd       <= '0;
                                r_state    <= S_EMIT;
                            end
                            itaf_pkg::OP_DEC: begin
                                r_pre      <= n_neg;
                                r_pre_byte <= itaf_pkg::ASCII_MINUS;
                                r_cr       <= 1'b0;
                                r_state    <= S_CONV;
                            end
                            itaf_pkg::OP_HEX: begin
                                r_pre   <= 1'b0;
                                r_cr    <= 1'b0;
                                r_buf   <= {n_val, (itaf_pkg::BUF_W - itaf_pkg::VALUE_W)'(0)};
                                r_nd    <= itaf_pkg::CNT_W'(itaf_pkg::HEX_DIGITS);
                                r_state <= S_TRIM;
                            end
                            itaf_pkg::OP_NONE: begin
                                r_state <= S_IDLE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    if (n_conv_done) begin
                        r_buf   <= n_bcd;
                        r_nd    <= itaf_pkg::CNT_W'(itaf_pkg::DEC_DIGITS);
                        r_state <= S_TRIM;
                    end
                end
                S_TRIM: begin
                    // drop leading zeros, always keep one digit
                    if ((r_nd > itaf_pkg::CNT_W'(1)) && (n_top == '0)) begin
                        r_buf <= r_buf << itaf_pkg::NIB_W;
                        r_nd  <= r_nd - 1'b1;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (n_slot) begin
                        priority if (r_pre) begin
                            r_pre      <= 1'b0;
                            r_out_byte <= r_pre_byte;
                            r_out_last <= (r_nd == '0) && !r_cr;
                            if ((r_nd == '0) && !r_cr) begin
                                r_state <= S_IDLE;
                            end
                        end else if (r_nd != '0) begin
                            r_buf      <= r_buf << itaf_pkg::NIB_W;
                            r_nd       <= r_nd - 1'b1;
                            r_out_byte <= itaf_pkg::digit_char(n_top);
                            r_out_last <= (r_nd == itaf_pkg::CNT_W'(1)) && !r_cr;
                            if ((r_nd == itaf_pkg::CNT_W'(1)) && !r_cr) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_cr       <= 1'b0;
                            r_out_byte <= itaf_pkg::ASCII_CR;
                            r_out_last <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

// ----- design/itaf_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
`default_nettype none
module itaf_dabble (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [itaf_pkg::VALUE_W-1:0]    i_bin,
    output logic                                 o_done,
    output logic [itaf_pkg::BUF_W-1:0]           o_bcd
);

    logic                              r_busy;
    logic                              r_done;
    logic [itaf_pkg::STEP_W-1:0]       r_step;
    logic [itaf_pkg::VALUE_W-1:0]      r_bin;
    logic [itaf_pkg::BUF_W-1:0]        r_bcd;
    logic [itaf_pkg::BUF_W-1:0]        n_adj;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < itaf_pkg::DEC_DIGITS; k++) begin
            if (r_bcd[k*itaf_pkg::NIB_W +: itaf_pkg::NIB_W] >= itaf_pkg::NIB_W'(5)) begin
                n_adj[k*itaf_pkg::NIB_W +: itaf_pkg::NIB_W] =
                    r_bcd[k*itaf_pkg::NIB_W +: itaf_pkg::NIB_W] + itaf_pkg::NIB_W'(3);
            end else begin
                n_adj[k*itaf_pkg::NIB_W +: itaf_pkg::NIB_W] =
                    r_bcd[k*itaf_pkg::NIB_W +: itaf_pkg::NIB_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // one-cycle pulse after the last shift
            r_done <= r_busy && !i_start &&
                      (r_step == itaf_pkg::STEP_W'(itaf_pkg::VALUE_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == itaf_pkg::STEP_W'(itaf_pkg::VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[itaf_pkg::VALUE_W-2:0], 1'b0};
            r_bcd <= {n_adj[itaf_pkg::BUF_W-2:0], r_bin[itaf_pkg::VALUE_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule
`default_nettype wire
